// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the frame rate sync RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, off while rst is high.
`define VFRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define VFRS_ASSERT_IMP(label, ante, cons, msg) \
  `VFRS_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define VFRS_ASSERT_NXT(label, ante, cons, msg) \
  `VFRS_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== design/vfrs_pkg.sv =====
// ---------------------------------------------------------------------------
// vfrs_pkg
// Shared constants, register map and types of the frame rate sync block.
// ---------------------------------------------------------------------------
package vfrs_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int PTS_WIDTH_DEF = 48;

  localparam int Q_W        = 64;         // internal fixed-point width
  localparam int MAG_W      = 62;         // saturated magnitude width
  localparam int REG_W      = 32;
  localparam int PROD_W     = Q_W + REG_W;
  localparam int MODE_W     = 2;
  localparam int CNT_W      = 8;
  localparam int DUR_W      = 16;
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  // 2^61 - 1, saturation bound of the scaled pts
  localparam logic signed [Q_W-1:0] LIM_Q = 64'sh1FFF_FFFF_FFFF_FFFF;

  localparam logic [MODE_W-1:0] MODE_CFR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_VFR = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_SYNC_MODE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PTS_SCALE  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_DUR  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_RESET  = MODE_CFR;
  localparam logic [REG_W-1:0]  SCALE_RESET = 32'h0001_0000;
  localparam logic [REG_W-1:0]  DUR_RESET   = 32'h0001_0000;

  typedef struct packed {
    logic [MODE_W-1:0] sync_mode;
    logic [REG_W-1:0]  pts_scale;
    logic [REG_W-1:0]  frame_duration;
  } cfg_t;

  typedef struct packed {
    logic                  present;
    logic signed [Q_W-1:0] fp;        // scaled pts
    logic signed [Q_W-1:0] fp_dur;    // fp + duration
    logic signed [Q_W-1:0] fp_m06;    // fp - 0.6
    logic signed [Q_W-1:0] fp_round;  // round(fp)
  } scaled_t;

endpackage

// ===== design/vfrs_if.sv =====
// ---------------------------------------------------------------------------
// vfrs_if
// Valid/ready channels carrying frame requests in and sync decisions out.
// ---------------------------------------------------------------------------
interface vfrs_in_if #(
  parameter int PTS_WIDTH = vfrs_pkg::PTS_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [PTS_WIDTH-1:0] frame_pts;
  logic                        frame_present;

  modport source (output valid, frame_pts, frame_present, input ready);
  modport sink   (input valid, frame_pts, frame_present, output ready);
endinterface

interface vfrs_out_if #(
  parameter int PTS_WIDTH = vfrs_pkg::PTS_WIDTH_DEF
);
  logic                             valid;
  logic                             ready;
  logic [vfrs_pkg::CNT_W-1:0]       emit_count;
  logic [vfrs_pkg::CNT_W-1:0]       repeat_previous_count;
  logic signed [PTS_WIDTH-1:0]      first_output_pts;
  logic [vfrs_pkg::DUR_W-1:0]       output_duration;

  modport source (output valid, emit_count, repeat_previous_count, first_output_pts,
                  output_duration, input ready);
  modport sink   (input valid, emit_count, repeat_previous_count, first_output_pts,
                  output_duration, output ready);
endinterface

// ===== design/vfrs_cfg.sv =====
// ---------------------------------------------------------------------------
// vfrs_cfg
// APB register file: sync mode, pts scale and frame duration.
// ---------------------------------------------------------------------------
module vfrs_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vfrs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [vfrs_pkg::REG_W-1:0]      pwdata,
  output logic [vfrs_pkg::REG_W-1:0]      prdata,
  output logic                            pready,
  output vfrs_pkg::cfg_t                  cfg
);
  import vfrs_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_mode      <= MODE_RESET;
      cfg.pts_scale      <= SCALE_RESET;
      cfg.frame_duration <= DUR_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SYNC_MODE: cfg.sync_mode      <= pwdata[MODE_W-1:0];
        REG_PTS_SCALE: cfg.pts_scale      <= pwdata;
        REG_FRAME_DUR: cfg.frame_duration <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SYNC_MODE: prdata = REG_W'(cfg.sync_mode);
      REG_PTS_SCALE: prdata = cfg.pts_scale;
      REG_FRAME_DUR: prdata = cfg.frame_duration;
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== design/vfrs_scale.sv =====
// ---------------------------------------------------------------------------
// vfrs_scale
// Input register and pts scaling pipeline: magnitude split multiply,
// saturation, then the state-independent sums used by the decision stage.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vfrs_scale #(
  parameter int FRAC_BITS = vfrs_pkg::FRAC_BITS_DEF,
  parameter int PTS_WIDTH = vfrs_pkg::PTS_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  vfrs_in_if.sink           frame_in,
  input  vfrs_pkg::cfg_t    cfg,
  output vfrs_pkg::scaled_t item,
  output logic              item_valid,
  input  logic              item_ready
);
  import vfrs_pkg::*;

  localparam logic signed [Q_W-1:0] ONE_Q  = Q_W'(1);
  localparam logic signed [Q_W-1:0] HALF_Q = ONE_Q <<< (FRAC_BITS - 1);
  localparam logic signed [Q_W-1:0] C06_Q  = (6 * (ONE_Q <<< FRAC_BITS) + 5) / 10;

  // stage valids and ready chain
  logic v0, v1, v2, v3;
  logic rdy0, rdy1, rdy2, rdy3;

  // stage 0: input register
  logic signed [PTS_WIDTH-1:0] pts0;
  logic                        present0;
  logic [PTS_WIDTH-1:0]        mag0;
  logic [Q_W-1:0]              mag0_q;

  // stage 1: partial products
  logic             present1, neg1;
  logic [Q_W-1:0]   pp_lo1, pp_hi1;
  logic [PROD_W-1:0] prod1;

  // stage 2: saturated magnitude
  logic             present2, neg2;
  logic [MAG_W-1:0] mag2;

  // stage 3 inputs
  logic signed [Q_W-1:0] mag_q, dur_q, rnd_q;
  scaled_t               s3;

  assign rdy3 = !v3 || item_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign rdy0 = !v0 || rdy1;
  assign frame_in.ready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy0) v0 <= frame_in.valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  assign mag0   = pts0[PTS_WIDTH-1] ? (~pts0 + 1'b1) : pts0;
  assign mag0_q = Q_W'(mag0);
  assign prod1  = (PROD_W'(pp_hi1) << REG_W) + PROD_W'(pp_lo1);

  assign mag_q = $signed(Q_W'(mag2));
  assign dur_q = $signed(Q_W'(cfg.frame_duration));
  assign rnd_q = (mag_q + HALF_Q) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rdy0) begin
      pts0     <= frame_in.frame_pts;
      present0 <= frame_in.frame_present;
    end
    if (rdy1) begin
      present1 <= present0;
      neg1     <= pts0[PTS_WIDTH-1];
      pp_lo1   <= Q_W'(mag0_q[REG_W-1:0]) * Q_W'(cfg.pts_scale);
      pp_hi1   <= Q_W'(mag0_q[Q_W-1:REG_W]) * Q_W'(cfg.pts_scale);
    end
    if (rdy2) begin
      present2 <= present1;
      neg2     <= neg1;
      mag2     <= (prod1 > PROD_W'(LIM_Q)) ? LIM_Q[MAG_W-1:0] : prod1[MAG_W-1:0];
    end
    if (rdy3) begin
      s3.present  <= present2;
      s3.fp       <= neg2 ? (~mag_q + ONE_Q) : mag_q;
      s3.fp_dur   <= neg2 ? (dur_q - mag_q) : (mag_q + dur_q);
      s3.fp_m06   <= neg2 ? (~mag_q + (ONE_Q - C06_Q)) : (mag_q - C06_Q);
      s3.fp_round <= neg2 ? -rnd_q : rnd_q;
    end
  end

  assign item       = s3;
  assign item_valid = v3;

  `VFRS_ASSERT_IMP(a_round_keeps_sign, v3 && !s3.fp[Q_W-1], !s3.fp_round[Q_W-1],
                   "rounded pts changed sign")

endmodule

// ===== design/vfrs_decide.sv =====
// ---------------------------------------------------------------------------
// vfrs_decide
// Drop / pass / duplicate decision against the expected pts, state update
// and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vfrs_decide #(
  parameter int FRAC_BITS = vfrs_pkg::FRAC_BITS_DEF,
  parameter int PTS_WIDTH = vfrs_pkg::PTS_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  vfrs_pkg::cfg_t    cfg,
  input  vfrs_pkg::scaled_t item,
  input  logic              item_valid,
  output logic              item_ready,
  vfrs_out_if.source        sync_out
);
  import vfrs_pkg::*;

  localparam logic signed [Q_W-1:0] ONE_Q   = Q_W'(1);
  localparam logic signed [Q_W-1:0] HALF_Q  = ONE_Q <<< (FRAC_BITS - 1);
  localparam logic signed [Q_W-1:0] C11_Q   = (11 * (ONE_Q <<< FRAC_BITS) + 5) / 10;
  localparam logic signed [Q_W-1:0] C06_Q   = (6 * (ONE_Q <<< FRAC_BITS) + 5) / 10;
  localparam logic signed [Q_W-1:0] TOP_Q   = LIM_Q >>> FRAC_BITS;
  localparam logic signed [Q_W-1:0] RLIM_Q  = (LIM_Q + HALF_Q) >>> FRAC_BITS;
  localparam logic signed [Q_W-1:0] CMAX_Q  = Q_W'({CNT_W{1'b1}});
  localparam logic signed [Q_W-1:0] DMAX_Q  = Q_W'({DUR_W{1'b1}});
  localparam logic signed [PTS_WIDTH-1:0] PMAX_P = {1'b0, {(PTS_WIDTH-1){1'b1}}};
  localparam logic signed [PTS_WIDTH-1:0] PMIN_P = {1'b1, {(PTS_WIDTH-1){1'b0}}};
  localparam logic signed [Q_W-1:0] PMAX_Q  = Q_W'(PMAX_P);
  localparam logic signed [Q_W-1:0] PMIN_Q  = Q_W'(PMIN_P);

  function automatic logic signed [Q_W-1:0] round_q(input logic signed [Q_W-1:0] v);
    return (v + (v[Q_W-1] ? (HALF_Q - ONE_Q) : HALF_Q)) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [PTS_WIDTH-1:0] clamp_q(input logic signed [Q_W-1:0] v);
    if (v > PMAX_Q) return PMAX_P;
    if (v < PMIN_Q) return PMIN_P;
    return v[PTS_WIDTH-1:0];
  endfunction

  function automatic logic signed [PTS_WIDTH-1:0] sat_add(
    input logic signed [PTS_WIDTH-1:0] a,
    input logic [CNT_W-1:0]            b
  );
    logic signed [PTS_WIDTH:0] s;
    s = $signed({a[PTS_WIDTH-1], a}) + $signed({{(PTS_WIDTH+1-CNT_W){1'b0}}, b});
    if (s > $signed({2'b00, {(PTS_WIDTH-1){1'b1}}})) return PMAX_P;
    return s[PTS_WIDTH-1:0];
  endfunction

  // state
  logic signed [PTS_WIDTH-1:0] expected;
  logic                        known;
  logic                        prev_valid;

  // result register
  logic                        out_valid;
  logic [CNT_W-1:0]            emit_cnt, rep_cnt;
  logic signed [PTS_WIDTH-1:0] first_pts;
  logic [DUR_W-1:0]            dur_reg;

  // decision logic
  logic                        load;
  logic signed [PTS_WIDTH-1:0] exp_first, exp_cur, rs_pts, exp_base;
  logic signed [Q_W-1:0]       e_q, eq, dl_raw, dl, dr, pm, dur_adj, dur_shift;
  logic signed [Q_W-1:0]       n_q, pre_q;
  logic                        eq_hi, eq_lo, snap, resync;
  logic [CNT_W-1:0]            n8, pre8, emit_next, rep_next;
  logic [DUR_W-1:0]            dur_mode, dur_next;
  logic signed [PTS_WIDTH-1:0] first_next, expected_next;
  logic                        known_next;

  assign item_ready = !out_valid || sync_out.ready;
  assign load       = item_valid && item_ready;

  always_comb begin
    exp_first = clamp_q(item.fp_round);
    exp_cur   = known ? expected : exp_first;
    e_q       = Q_W'(exp_cur);
    eq_hi     = e_q > TOP_Q;
    eq_lo     = e_q < -TOP_Q;
    if (eq_hi) begin
      eq = LIM_Q;
    end else if (eq_lo) begin
      eq = -LIM_Q;
    end else begin
      eq = e_q <<< FRAC_BITS;
    end

    dl_raw  = item.fp - eq;
    dr      = item.fp_dur - eq;
    pm      = item.fp_m06 - eq;
    snap    = (dl_raw < 0) && (dr > 0);
    dl      = snap ? '0 : dl_raw;
    dur_adj = snap ? dr : $signed(Q_W'(cfg.frame_duration));

    // round of the snapped pts
    if (!snap) begin
      rs_pts = exp_first;
    end else if (eq_hi) begin
      rs_pts = clamp_q(RLIM_Q);
    end else if (eq_lo) begin
      rs_pts = clamp_q(-RLIM_Q);
    end else begin
      rs_pts = exp_cur;
    end

    n_q       = ONE_Q;
    pre_q     = '0;
    dur_mode  = '0;
    resync    = 1'b0;
    dur_shift = dur_adj >>> FRAC_BITS;
    case (cfg.sync_mode)
      MODE_CFR: begin
        if (dr < -C11_Q) begin
          n_q = '0;
        end else if (dr > C11_Q) begin
          n_q = round_q(dr);
          if (dl > C11_Q) pre_q = round_q(pm);
        end
        dur_mode = DUR_W'(1);
      end
      MODE_VFR: begin
        if (dr <= -C06_Q) begin
          n_q = '0;
        end else if (dr > C06_Q) begin
          resync = 1'b1;
        end
        dur_mode = (dur_shift > DMAX_Q) ? {DUR_W{1'b1}} : dur_shift[DUR_W-1:0];
      end
      default: ;
    endcase

    n8 = (n_q > CMAX_Q) ? {CNT_W{1'b1}} : n_q[CNT_W-1:0];
    if (!prev_valid || pre_q < 0) begin
      pre8 = '0;
    end else if (pre_q > $signed(Q_W'(n8))) begin
      pre8 = n8;
    end else begin
      pre8 = pre_q[CNT_W-1:0];
    end
    exp_base = resync ? rs_pts : exp_cur;

    if (!item.present) begin
      emit_next     = CNT_W'(1);
      rep_next      = '0;
      dur_next      = '0;
      first_next    = expected;
      expected_next = known ? sat_add(expected, CNT_W'(1)) : expected;
      known_next    = known;
    end else begin
      emit_next     = n8;
      rep_next      = pre8;
      dur_next      = dur_mode;
      first_next    = exp_base;
      expected_next = sat_add(exp_base, n8);
      known_next    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      expected   <= '0;
      known      <= 1'b0;
      prev_valid <= 1'b0;
    end else if (load) begin
      out_valid  <= 1'b1;
      expected   <= expected_next;
      known      <= known_next;
      prev_valid <= item.present;
    end else if (sync_out.ready) begin
      out_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      emit_cnt  <= emit_next;
      rep_cnt   <= rep_next;
      first_pts <= first_next;
      dur_reg   <= dur_next;
    end
  end

  assign sync_out.valid                 = out_valid;
  assign sync_out.emit_count            = emit_cnt;
  assign sync_out.repeat_previous_count = rep_cnt;
  assign sync_out.first_output_pts      = first_pts;
  assign sync_out.output_duration       = dur_reg;

  `VFRS_ASSERT_IMP(a_repeat_le_emit, out_valid, rep_cnt <= emit_cnt,
                   "repeat count exceeds emit count")
  `VFRS_ASSERT_NXT(a_known_sticks, known, known,
                   "expected pts lost outside reset")
  `VFRS_ASSERT_NXT(a_no_repeat_after_flush, load && !prev_valid, rep_cnt == '0,
                   "repeat of previous frame with no previous frame")

endmodule

// ===== design/video_frame_rate_sync.sv =====
// ---------------------------------------------------------------------------
// video_frame_rate_sync
// Per-frame drop / pass / duplicate decision for constant or variable
// frame rate encoding, in fixed-point codec ticks.
// ---------------------------------------------------------------------------
//  channel    kind        direction  carries
//  frame_in   valid/ready in         frame_pts, frame_present
//  sync_out   valid/ready out        emit_count, repeat_previous_count,
//                                    first_output_pts, output_duration
//  APB        psel/pen.   in/out     sync_mode, pts_scale, frame_duration
//
//  One request per cycle sustained while sync_out is ready; a result leaves
//  through the input register, two multiply/saturate stages, one sum stage
//  and the result register. The expected pts loop closes in the decision
//  stage. Synchronous reset clears all valids and state, no clearing pass.
//  Stalls on sync_out fill the stages before frame_in ready drops.
// ---------------------------------------------------------------------------
module video_frame_rate_sync #(
  parameter int FRAC_BITS = vfrs_pkg::FRAC_BITS_DEF,
  parameter int PTS_WIDTH = vfrs_pkg::PTS_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  vfrs_in_if.sink                         frame_in,
  vfrs_out_if.source                      sync_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vfrs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [vfrs_pkg::REG_W-1:0]      pwdata,
  output logic [vfrs_pkg::REG_W-1:0]      prdata,
  output logic                            pready
);
  import vfrs_pkg::*;

  cfg_t    cfg;
  scaled_t item;
  logic    item_valid;
  logic    item_ready;

  vfrs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vfrs_scale #(
    .FRAC_BITS (FRAC_BITS),
    .PTS_WIDTH (PTS_WIDTH)
  ) u_scale (
    .clk        (clk),
    .rst        (rst),
    .frame_in   (frame_in),
    .cfg        (cfg),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready)
  );

  vfrs_decide #(
    .FRAC_BITS (FRAC_BITS),
    .PTS_WIDTH (PTS_WIDTH)
  ) u_decide (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sync_out   (sync_out)
  );

endmodule

// ===== verif/video_frame_rate_sync_tb.sv =====
// ---------------------------------------------------------------------------
// video_frame_rate_sync_tb
// Self-checking bench for the frame rate sync block. A short directed sequence
// walks the drop / pass / duplicate cases, flushes, saturation and every sync
// mode, then randomized phases reprogram the registers over APB and feed
// mostly in-order timestamp runs mixed with noise and flushes. Each decision
// is compared field by field with an in-bench predictor or a typed row's expectation.
// ---------------------------------------------------------------------------
module video_frame_rate_sync_tb;
  import vfrs_pkg::*;

  localparam int FRAC  = FRAC_BITS_DEF;
  localparam int PTS_W = PTS_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 6;
  localparam int PHASE_REQUESTS = 125;

  localparam logic [MODE_W-1:0] MODE_PASS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam longint SAT_TICKS = (longint'(1) <<< 61) - 1;
  localparam longint TOL_1P1   = (11 * (longint'(1) <<< FRAC) + 5) / 10;
  localparam longint TOL_0P6   = (6 * (longint'(1) <<< FRAC) + 5) / 10;
  localparam longint PTS_MAX   = (longint'(1) <<< (PTS_W - 1)) - 1;
  localparam longint PTS_MIN   = -PTS_MAX - 1;

  localparam logic signed [PTS_W-1:0] PTS_HI = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [PTS_W-1:0] PTS_LO = 48'sh8000_0000_0000;

  typedef struct packed {
    logic [CNT_W-1:0]        emit_count;
    logic [CNT_W-1:0]        reuse_count;
    logic signed [PTS_W-1:0] first_pts;
    logic [DUR_W-1:0]        duration;
  } sync_decision_t;

  typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [REG_IDX_W-1:0]    reg_idx;
    logic [REG_W-1:0]        reg_value;
    logic signed [PTS_W-1:0] pts;
    logic                    present;
    logic                    typed;
    sync_decision_t          want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [REG_W-1:0] pwdata, prdata;

  vfrs_in_if  frame_in_ch();
  vfrs_out_if sync_out_ch();

  video_frame_rate_sync dut (
    .clk      (clk),
    .rst      (rst),
    .frame_in (frame_in_ch),
    .sync_out (sync_out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // predictor state
  logic [MODE_W-1:0] cfg_mode;
  logic [REG_W-1:0]  cfg_scale;
  logic [REG_W-1:0]  cfg_duration;
  longint            exp_ticks;
  bit                exp_known;
  bit                last_was_frame;

  sync_decision_t pending_decisions[$];
  stim_row_t      directed_rows[$];

  int fail_count;
  int requests_sent;
  int decisions_checked;
  int drops_seen;
  int dups_seen;
  int flushes_sent;
  int burst_left;
  int cycle_count;
  int stall_tick;
  int stall_style;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint clamp_pts(longint v);
    if (v > PTS_MAX) return PTS_MAX;
    if (v < PTS_MIN) return PTS_MIN;
    return v;
  endfunction

  function automatic longint round_ticks(longint v);
    longint half;
    half = longint'(1) <<< (FRAC - 1);
    if (v >= 0) return (v + half) >>> FRAC;
    return -(((-v) + half) >>> FRAC);
  endfunction

  // exact pts * scale, saturated to +-2^61-1
  function automatic longint scale_to_ticks(logic signed [PTS_W-1:0] pts, logic [REG_W-1:0] s);
    logic [PTS_W-1:0] mag;
    logic [79:0]      prod;
    longint           tot;
    mag  = pts[PTS_W-1] ? (~pts + 1'b1) : pts;
    prod = mag * s;
    tot  = (prod > 80'(SAT_TICKS)) ? SAT_TICKS : longint'(prod[63:0]);
    return pts[PTS_W-1] ? -tot : tot;
  endfunction

  function automatic longint ticks_to_q(longint e);
    longint top;
    top = SAT_TICKS >>> FRAC;
    if (e > top) return SAT_TICKS;
    if (e < -top) return -SAT_TICKS;
    return e <<< FRAC;
  endfunction

  function automatic sync_decision_t predict_decision(logic signed [PTS_W-1:0] pts,
                                                      logic present);
    sync_decision_t d;
    longint fp, dur, eq, dl, dr, n, pre, dur_q;
    n = 1;
    pre = 0;
    dur_q = 0;
    if (!present) begin
      d.emit_count = 1;
      d.reuse_count = 0;
      d.duration = 0;
      d.first_pts = exp_ticks[PTS_W-1:0];
      if (exp_known) exp_ticks = clamp_pts(exp_ticks + 1);
      last_was_frame = 0;
      return d;
    end
    fp  = scale_to_ticks(pts, cfg_scale);
    dur = longint'(cfg_duration);
    if (!exp_known) begin
      exp_ticks = clamp_pts(round_ticks(fp));
      exp_known = 1;
    end
    eq = ticks_to_q(exp_ticks);
    dl = fp - eq;
    dr = dl + dur;
    // near on time: snap to the expected slot
    if (dl < 0 && dr > 0) begin
      fp  = eq;
      dur = dur + dl;
      dl  = 0;
    end
    if (cfg_mode == MODE_CFR) begin
      if (dr < -TOL_1P1) begin
        n = 0;
      end else if (dr > TOL_1P1) begin
        n = round_ticks(dr);
        if (dl > TOL_1P1) pre = round_ticks(dl - TOL_0P6);
      end
      dur_q = 1;
    end else if (cfg_mode == MODE_VFR) begin
      if (dr <= -TOL_0P6) n = 0;
      else if (dr > TOL_0P6) exp_ticks = clamp_pts(round_ticks(fp));
      dur_q = dur >>> FRAC;
      if (dur_q > 65535) dur_q = 65535;
    end
    if (n > 255) n = 255;
    if (pre > n) pre = n;
    if (pre < 0 || !last_was_frame) pre = 0;
    d.first_pts = exp_ticks[PTS_W-1:0];
    exp_ticks = clamp_pts(exp_ticks + n);
    last_was_frame = 1;
    d.emit_count = n[CNT_W-1:0];
    d.reuse_count = pre[CNT_W-1:0];
    d.duration = dur_q[DUR_W-1:0];
    return d;
  endfunction

  function automatic stim_row_t frame_row(logic signed [PTS_W-1:0] pts, logic present);
    stim_row_t r;
    r = '0;
    r.kind = ROW_FRAME;
    r.pts = pts;
    r.present = present;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic signed [PTS_W-1:0] pts, logic present,
                                          int n, int pre, longint first, int dur);
    stim_row_t r;
    r = frame_row(pts, present);
    r.typed = 1'b1;
    r.want = '{n[CNT_W-1:0], pre[CNT_W-1:0], first[PTS_W-1:0], dur[DUR_W-1:0]};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_value = value;
    return r;
  endfunction

  function automatic logic [REG_W-1:0] pick_q16();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom();
      default: return $urandom_range(32'h0000_4000, 32'h0004_0000);
    endcase
  endfunction

  // APB write, then read back
  task automatic program_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
    logic [REG_W-1:0] stored;
    stored = (idx == REG_SYNC_MODE) ? (value & 32'h3) : value;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SYNC_MODE: cfg_mode = value[MODE_W-1:0];
      REG_PTS_SCALE: cfg_scale = value;
      REG_FRAME_DUR: cfg_duration = value;
      default: ;
    endcase
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== stored) begin
      $error("register %0d readback: expected %h, got %h", idx, stored, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // one frame request; valid stays up across a burst
  task automatic push_request(logic signed [PTS_W-1:0] pts, logic present,
                              logic typed, sync_decision_t want);
    sync_decision_t d;
    @(negedge clk);
    frame_in_ch.valid = 1'b1;
    frame_in_ch.frame_pts = pts;
    frame_in_ch.frame_present = present;
    do @(posedge clk); while (!frame_in_ch.ready);
    d = predict_decision(pts, present);
    pending_decisions.push_back(typed ? want : d);
    requests_sent++;
    if (!present) flushes_sent++;
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      @(negedge clk);
      frame_in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  task automatic settle_idle();
    @(negedge clk);
    frame_in_ch.valid = 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 48 == 0) stall_style = $urandom_range(0, 3);
    case (stall_style)
      0: sync_out_ch.ready = 1'b1;
      1: sync_out_ch.ready = 1'($urandom_range(0, 1));
      2: sync_out_ch.ready = ($urandom_range(0, 3) == 0);
      default: sync_out_ch.ready = (stall_tick % 5) != 0;
    endcase
  end

  always @(posedge clk) begin
    sync_decision_t want;
    if (!rst && sync_out_ch.valid && sync_out_ch.ready) begin
      if (pending_decisions.size() == 0) begin
        $error("decision with no request outstanding");
        fail_count++;
      end else begin
        want = pending_decisions.pop_front();
        decisions_checked++;
        if (sync_out_ch.emit_count == 0) drops_seen++;
        if (sync_out_ch.emit_count > 1) dups_seen++;
        if (sync_out_ch.emit_count !== want.emit_count) begin
          $error("emit_count: expected %0d, got %0d", want.emit_count,
                 sync_out_ch.emit_count);
          fail_count++;
        end
        if (sync_out_ch.repeat_previous_count !== want.reuse_count) begin
          $error("repeat_previous_count: expected %0d, got %0d", want.reuse_count,
                 sync_out_ch.repeat_previous_count);
          fail_count++;
        end
        if (sync_out_ch.first_output_pts !== want.first_pts) begin
          $error("first_output_pts: expected %0d, got %0d", want.first_pts,
                 sync_out_ch.first_output_pts);
          fail_count++;
        end
        if (sync_out_ch.output_duration !== want.duration) begin
          $error("output_duration: expected %0d, got %0d", want.duration,
                 sync_out_ch.output_duration);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d decisions outstanding", pending_decisions.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    longint track;
    longint step;
    bit resync;
    int r;
    logic signed [PTS_W-1:0] pts;
    logic [MODE_W-1:0] phase_modes [PHASES];

    phase_modes = '{MODE_CFR, MODE_VFR, MODE_CFR, MODE_PASS, MODE_VFR, MODE_UNUSED};
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    frame_in_ch.valid = 1'b0;
    frame_in_ch.frame_pts = '0;
    frame_in_ch.frame_present = 1'b0;
    sync_out_ch.ready = 1'b0;
    cfg_mode = MODE_RESET;
    cfg_scale = SCALE_RESET;
    cfg_duration = DUR_RESET;
    exp_ticks = 0;
    exp_known = 0;
    last_was_frame = 0;
    burst_left = 4;
    track = 0;

    directed_rows = '{
      typed_row(0, 1'b1, 1, 0, 0, 1),              // first frame sets the slot
      typed_row(0, 1'b0, 1, 0, 1, 0),              // flush
      typed_row(2, 1'b1, 1, 0, 2, 1),              // no previous frame
      typed_row(10, 1'b1, 8, 6, 3, 1),             // duplicate with leading repeats
      typed_row(5, 1'b1, 0, 0, 11, 1),             // late frame dropped
      typed_row(PTS_HI, 1'b1, 255, 255, 11, 1),    // saturated scale and counts
      typed_row(PTS_LO, 1'b1, 0, 0, 266, 1),
      frame_row(266, 1'b1),
      frame_row(267, 1'b1),
      cfg_row(REG_SYNC_MODE, MODE_VFR),
      cfg_row(REG_PTS_SCALE, 32'h0000_8000),
      cfg_row(REG_FRAME_DUR, 32'h0001_8000),
      frame_row(600, 1'b1),                        // resync
      frame_row(601, 1'b1),                        // snap to slot
      frame_row(590, 1'b1),                        // drop
      frame_row(0, 1'b0),
      frame_row(620, 1'b1),
      cfg_row(REG_FRAME_DUR, 32'hFFFF_FFFF),
      frame_row(660, 1'b1),                        // duration field saturates
      cfg_row(REG_PTS_SCALE, 32'hFFFF_FFFF),
      cfg_row(REG_FRAME_DUR, 32'h0000_0000),
      frame_row(-1, 1'b1),
      frame_row(3, 1'b1),
      cfg_row(REG_SYNC_MODE, MODE_PASS),
      frame_row(12345, 1'b1),
      frame_row(0, 1'b0),
      cfg_row(REG_SYNC_MODE, MODE_UNUSED),
      frame_row(-5000, 1'b1),
      cfg_row(REG_SYNC_MODE, MODE_CFR),
      cfg_row(REG_PTS_SCALE, 32'h0000_0000),
      cfg_row(REG_FRAME_DUR, 32'h0001_0000),
      frame_row(777, 1'b1),
      frame_row(-777, 1'b1),
      cfg_row(REG_PTS_SCALE, 32'h0001_0000),
      frame_row(0, 1'b0),
      frame_row(100000, 1'b1)                      // big jump right after a flush
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle_idle();
        program_reg(directed_rows[i].reg_idx, directed_rows[i].reg_value);
      end else begin
        push_request(directed_rows[i].pts, directed_rows[i].present,
                     directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle_idle();
      program_reg(REG_SYNC_MODE, phase_modes[ph]);
      program_reg(REG_PTS_SCALE, pick_q16());
      program_reg(REG_FRAME_DUR, pick_q16());
      resync = 1;
      for (int k = 0; k < PHASE_REQUESTS; k++) begin
        r = $urandom_range(0, 99);
        pts = PTS_W'({$urandom(), $urandom()});
        if (r < 6) begin
          push_request(pts, 1'b0, 1'b0, '0);
        end else if (r < 10) begin
          push_request(pts, 1'b1, 1'b0, '0);
          resync = 1;
        end else if (r < 12) begin
          case ($urandom_range(0, 3))
            0: pts = PTS_HI;
            1: pts = PTS_LO;
            2: pts = '0;
            default: pts = '1;
          endcase
          push_request(pts, 1'b1, 1'b0, '0);
          resync = 1;
        end else begin
          // follow the expected slot so most frames land near on time
          if (resync) begin
            if (cfg_scale != 0 && exp_ticks < (longint'(1) <<< 40) &&
                exp_ticks > -(longint'(1) <<< 40)) begin
              track = (exp_ticks <<< FRAC) / longint'(cfg_scale);
            end else begin
              track = longint'($urandom_range(0, 100000)) - 50000;
            end
            resync = 0;
          end
          r = $urandom_range(0, 19);
          if (r < 14) step = longint'($urandom_range(0, 3));
          else if (r < 17) step = -longint'($urandom_range(0, 3));
          else step = longint'($urandom_range(4, 400));
          track = clamp_pts(track + step);
          push_request(track[PTS_W-1:0], 1'b1, 1'b0, '0);
        end
      end
    end

    settle_idle();
    repeat (12) @(posedge clk);

    $display("%0d frame requests (%0d flushes) across %0d register phases",
             requests_sent, flushes_sent, PHASES + 7);
    $display("%0d decisions checked: %0d drops, %0d duplicates",
             decisions_checked, drops_seen, dups_seen);
    if (pending_decisions.size() != 0) begin
      $error("%0d decisions never arrived", pending_decisions.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
